>>> rtl/lpsm_pkg.sv
// ----------------------------------------------------------------------------
// lpsm_pkg
// Shared types and constants for the layer priority shadow/highlight mixer.
// ----------------------------------------------------------------------------
package lpsm_pkg;

  localparam int unsigned PixelW   = 7;
  localparam int unsigned IndexW   = 9;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  // register index taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_BG_COLOR  = 2'd0,
    REG_SH_ON     = 2'd1,
    REG_DISP_ON   = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  // pixel source picked by the priority network
  typedef enum logic [1:0] {
    SRC_A  = 2'd0,
    SRC_B  = 2'd1,
    SRC_S  = 2'd2,
    SRC_BG = 2'd3
  } src_e;

  // palette modes
  localparam logic [ModeW-1:0] ModeShadow    = 2'd0;
  localparam logic [ModeW-1:0] ModeNormal    = 2'd1;
  localparam logic [ModeW-1:0] ModeHighlight = 2'd2;

  // sprite operator codes
  localparam logic [PixelW-1:0] SprNormalLo = 7'h70;
  localparam logic [PixelW-1:0] SprNormalHi = 7'h72;
  localparam logic [PixelW-1:0] SprHilite   = 7'h73;
  localparam logic [PixelW-1:0] SprShadow   = 7'h7b;

  // decoded layer flags from the first stage
  typedef struct packed {
    logic a_opaque;
    logic a_strong;
    logic a_pri;
    logic b_opaque;
    logic b_strong;
    logic b_pri;
    logic s_opaque;
    logic s_strong;
    logic s_pri;
    logic s_force_normal;
    logic s_hilite;
    logic s_shadow;
  } layer_flags_t;

endpackage

>>> rtl/layer_priority_shadow_mixer.sv
// ----------------------------------------------------------------------------
// layer_priority_shadow_mixer
// Per-pixel compositor of plane A, plane B and sprite with shadow/highlight
// palette modes, configured through an APB-style register port.
// ----------------------------------------------------------------------------
// A request moves through stage 1, 2 and 3 registers. Throughput: one pixel
// per cycle while the output is not stalled; the three stages each hold one
// request and advance independently, so bubbles close up under output stall.
// Reset: pipeline valid bits clear; background colour, shadow/highlight
// enable and display enable all reset to zero.
module layer_priority_shadow_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // apb register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpsm_pkg::AddrW-1:0]      paddr,
  input  logic [lpsm_pkg::DataW-1:0]      pwdata,
  output logic [lpsm_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [lpsm_pkg::PixelW-1:0]     plane_a_pixel_i,
  input  logic [lpsm_pkg::PixelW-1:0]     plane_b_pixel_i,
  input  logic [lpsm_pkg::PixelW-1:0]     sprite_pixel_i,
  // mixed output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [lpsm_pkg::IndexW-1:0]     palette_index_o,
  output logic                            blank_o
);

  // configuration registers
  logic [lpsm_pkg::PixelW-1:0] bg_color_q;
  logic                        sh_on_q;
  logic                        disp_on_q;
  logic                        cfg_wr;
  lpsm_pkg::reg_idx_e          reg_idx;

  // pipeline control
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  // stage 1 payload
  lpsm_pkg::layer_flags_t      flags_q;
  logic [lpsm_pkg::PixelW-1:0] a1_q, b1_q, s1_q;

  // stage 2 logic and payload
  lpsm_pkg::src_e              back_src, front_src, sel_src;
  logic [lpsm_pkg::ModeW-1:0]  base_mode, mode_d;
  logic [lpsm_pkg::PixelW-1:0] color_d;
  logic [lpsm_pkg::ModeW-1:0]  mode_q;
  logic [lpsm_pkg::PixelW-1:0] color_q;

  // stage 3 payload
  logic [lpsm_pkg::IndexW-1:0] index_d, index_q;
  logic                        blank_q;

  lpsm_pkg::layer_flags_t      flags_d;

  // register port decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = lpsm_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_color_q <= '0;
      sh_on_q    <= 1'b0;
      disp_on_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        lpsm_pkg::REG_BG_COLOR: bg_color_q <= pwdata[lpsm_pkg::PixelW-1:0];
        lpsm_pkg::REG_SH_ON:    sh_on_q    <= pwdata[0];
        lpsm_pkg::REG_DISP_ON:  disp_on_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      lpsm_pkg::REG_BG_COLOR: prdata[lpsm_pkg::PixelW-1:0] = bg_color_q;
      lpsm_pkg::REG_SH_ON:    prdata[0] = sh_on_q;
      lpsm_pkg::REG_DISP_ON:  prdata[0] = disp_on_q;
      default:                prdata = '0;
    endcase
  end

  // each stage loads when empty or when the one after it moves on
  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: decode opacity, priority and sprite operator codes
  always_comb begin
    flags_d.a_opaque       = |plane_a_pixel_i[6:3];
    flags_d.a_pri          = plane_a_pixel_i[2];
    flags_d.a_strong       = flags_d.a_opaque & flags_d.a_pri;
    flags_d.b_opaque       = |plane_b_pixel_i[6:3];
    flags_d.b_pri          = plane_b_pixel_i[2];
    flags_d.b_strong       = flags_d.b_opaque & flags_d.b_pri;
    flags_d.s_opaque       = |sprite_pixel_i[6:3];
    flags_d.s_pri          = sprite_pixel_i[2];
    flags_d.s_strong       = flags_d.s_opaque & flags_d.s_pri;
    flags_d.s_force_normal = (sprite_pixel_i >= lpsm_pkg::SprNormalLo) &&
                             (sprite_pixel_i <= lpsm_pkg::SprNormalHi);
    flags_d.s_hilite       = (sprite_pixel_i == lpsm_pkg::SprHilite);
    flags_d.s_shadow       = (sprite_pixel_i == lpsm_pkg::SprShadow);
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      flags_q <= flags_d;
      a1_q    <= plane_a_pixel_i;
      b1_q    <= plane_b_pixel_i;
      s1_q    <= sprite_pixel_i;
    end
  end

  // stage 2: priority network, mode and colour select
  always_comb begin
    if (flags_q.a_strong || (flags_q.a_opaque && !flags_q.b_strong)) begin
      back_src = lpsm_pkg::SRC_A;
    end else if (flags_q.b_opaque) begin
      back_src = lpsm_pkg::SRC_B;
    end else begin
      back_src = lpsm_pkg::SRC_BG;
    end

    if (flags_q.s_strong ||
        (flags_q.s_opaque && !flags_q.b_strong && !flags_q.a_strong)) begin
      front_src = lpsm_pkg::SRC_S;
    end else begin
      front_src = back_src;
    end

    base_mode = {1'b0, flags_q.a_pri | flags_q.b_pri};
    sel_src   = front_src;

    if (!sh_on_q) begin
      mode_d = lpsm_pkg::ModeNormal;
    end else if (front_src == lpsm_pkg::SRC_S) begin
      if (flags_q.s_force_normal) begin
        mode_d = lpsm_pkg::ModeNormal;
      end else if (flags_q.s_hilite) begin
        sel_src = back_src;
        mode_d  = base_mode + lpsm_pkg::ModeNormal;
      end else if (flags_q.s_shadow) begin
        sel_src = back_src;
        mode_d  = lpsm_pkg::ModeShadow;
      end else begin
        mode_d  = base_mode | {1'b0, flags_q.s_pri};
      end
    end else begin
      mode_d = base_mode;
    end

    case (sel_src)
      lpsm_pkg::SRC_A:  color_d = a1_q;
      lpsm_pkg::SRC_B:  color_d = b1_q;
      lpsm_pkg::SRC_S:  color_d = s1_q;
      lpsm_pkg::SRC_BG: color_d = bg_color_q;
      default:          color_d = bg_color_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      mode_q  <= mode_d;
      color_q <= color_d;
    end
  end

  // stage 3: palette index assembly and blanking
  assign index_d = disp_on_q ? {mode_q, color_q} : '0;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      index_q <= index_d;
      blank_q <= !disp_on_q;
    end
  end

  assign out_valid_o     = v3_q;
  assign palette_index_o = index_q;
  assign blank_o         = blank_q;

endmodule
